@@ design/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_IN_W = 32;
    localparam int RESULT_W    = 33;
    localparam int CFG_W       = 7;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    typedef logic [1:0] t_cell_op;

    localparam t_cell_op OP_HOLD   = 2'd0;
    localparam t_cell_op OP_REMOVE = 2'd1;
    localparam t_cell_op OP_INSERT = 2'd2;

endpackage

@@ design/swm_in_if.sv @@
// ----------------------------------------------------------------------------
// swm_in_if
// Sample channel: valid, ready, sample and restart flag.
// ----------------------------------------------------------------------------
interface swm_in_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [swm_pkg::SAMPLE_IN_W-1:0] sample;
    logic                                   restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);

endinterface

@@ design/swm_out_if.sv @@
// ----------------------------------------------------------------------------
// swm_out_if
// Result channel: valid, ready and twice the window median.
// ----------------------------------------------------------------------------
interface swm_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [swm_pkg::RESULT_W-1:0] median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);

endinterface

@@ design/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted chain. Shifts towards its left or right neighbour
// to remove the leaving sample or to make room for the entering one.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SW    = 32,
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic                  i_clk,
    input  swm_pkg::t_cell_op     i_op,
    input  logic signed [SW-1:0]  i_value,
    input  logic [CNT_W-1:0]      i_count,
    input  logic signed [SW-1:0]  i_left,
    input  logic signed [SW-1:0]  i_right,
    output logic signed [SW-1:0]  o_value
);

    localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);
    localparam logic             HAS_LEFT = (INDEX > 0);

    logic signed [SW-1:0] r_value;
    logic signed [SW-1:0] n_value;
    logic                 w_left_gt;

    assign w_left_gt = HAS_LEFT && (i_left > i_value);

    always_comb begin
        n_value = r_value;
        case (i_op)
            swm_pkg::OP_REMOVE: begin
                if ((IDX_NEXT < i_count) && (r_value >= i_value)) begin
                    n_value = i_right;
                end
            end
            swm_pkg::OP_INSERT: begin
                if (IDX <= i_count) begin
                    if (w_left_gt) begin
                        n_value = i_left;
                    end else if ((IDX == i_count) || (r_value > i_value)) begin
                        n_value = i_value;
                    end
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ design/sliding_window_median_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Streaming median filter over the most recent window_size samples.
//
// i_in carries one sample per item with a restart flag; o_out carries twice
// the window median. i_cfg_we with i_cfg_wdata writes window_size (zero acts
// as one, values above WINDOW_MAX as WINDOW_MAX) and empties the window.
// Samples sit in an arrival ring memory and in a sorted chain of cells.
// Until the window has filled, an item gives no result: ring read, then
// insertion shift. The item that fills the window adds the median add;
// every later item takes ring read, removal shift through the chain,
// insertion shift and median add. One item is in work at a time; a
// finished result waits in the output register, so the next item is
// taken while the receiver stalls; the median stage holds only if that
// register is still full.
// Reset (synchronous, i_rst_n low) empties the window and sets window_size
// to 3; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_median_unit #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]   i_cfg_wdata,
    swm_in_if.sink                      i_in,
    swm_out_if.source                   o_out
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW    = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;
    localparam int OW    = swm_pkg::RESULT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_REM  = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_MED  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [swm_pkg::CFG_W-1:0] r_window_size;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic [AW-1:0]           r_ptr, n_ptr;
    logic                    r_emit, n_emit;
    logic [CNT_W-1:0]        r_ins_count, n_ins_count;
    logic signed [SW-1:0]    r_sample;
    logic signed [SW-1:0]    r_old;
    logic signed [SW-1:0]    r_ring [WINDOW_MAX];
    logic                    r_out_valid;
    logic signed [OW-1:0]    r_out_data;

    logic [CW-1:0]           w_cfg_ext;
    logic [CNT_W-1:0]        w_k;
    logic                    w_accept;
    logic [CNT_W-1:0]        w_f;
    logic [AW-1:0]           w_p;
    logic [AW-1:0]           w_addr;
    logic signed [SW-1:0]    w_in_sample;
    logic                    w_load_out;

    swm_pkg::t_cell_op       w_op;
    logic signed [SW-1:0]    w_cell_value;
    logic [CNT_W-1:0]        w_cell_count;
    logic signed [SW-1:0]    w_cell [WINDOW_MAX];

    logic [CNT_W-1:0]        w_lo_idx, w_hi_idx;
    logic signed [SW-1:0]    w_lo, w_hi;
    logic signed [OW-1:0]    w_sum;

    // effective window size
    assign w_cfg_ext = CW'(r_window_size);
    assign w_k = (w_cfg_ext == '0) ? CNT_W'(1) :
                 (w_cfg_ext > CW'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) :
                 CNT_W'(w_cfg_ext);

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_in_sample = SW'(i_in.sample);

    assign w_f    = i_in.restart ? '0 : r_fill;
    assign w_p    = i_in.restart ? '0 : r_ptr;
    assign w_addr = (w_f < w_k) ? w_f[AW-1:0] : w_p;

    assign w_load_out = (r_state == S_MED) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_emit      = r_emit;
        n_ins_count = r_ins_count;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_f < w_k) begin
                        n_fill      = w_f + CNT_W'(1);
                        n_ptr       = '0;
                        n_emit      = ((w_f + CNT_W'(1)) == w_k);
                        n_ins_count = w_f;
                        n_state     = S_INS;
                    end else begin
                        n_fill      = w_f;
                        n_ptr       = ((CNT_W'(w_p) + CNT_W'(1)) == w_k) ? '0 :
                                      w_p + AW'(1);
                        n_emit      = 1'b1;
                        n_ins_count = w_k - CNT_W'(1);
                        n_state     = S_REM;
                    end
                end
            end
            S_REM: begin
                n_state = S_INS;
            end
            S_INS: begin
                n_state = r_emit ? S_MED : S_IDLE;
            end
            S_MED: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_fill = '0;
            n_ptr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_size <= swm_pkg::WINDOW_SIZE_RESET;
            r_fill        <= '0;
            r_ptr         <= '0;
            r_emit        <= 1'b0;
            r_ins_count   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_emit      <= n_emit;
            r_ins_count <= n_ins_count;
            if (i_cfg_we) begin
                r_window_size <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arrival ring, read before write
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_old          <= r_ring[w_addr];
            r_ring[w_addr] <= w_in_sample;
            r_sample       <= w_in_sample;
        end
    end

    // sorted chain
    always_comb begin
        case (r_state)
            S_REM: begin
                w_op         = swm_pkg::OP_REMOVE;
                w_cell_value = r_old;
                w_cell_count = w_k;
            end
            S_INS: begin
                w_op         = swm_pkg::OP_INSERT;
                w_cell_value = r_sample;
                w_cell_count = r_ins_count;
            end
            default: begin
                w_op         = swm_pkg::OP_HOLD;
                w_cell_value = r_sample;
                w_cell_count = r_ins_count;
            end
        endcase
    end

    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        logic signed [SW-1:0] w_left;
        logic signed [SW-1:0] w_right;
        if (gi > 0) begin : g_l
            assign w_left = w_cell[gi-1];
        end else begin : g_l0
            assign w_left = w_cell[gi];
        end
        if (gi < WINDOW_MAX - 1) begin : g_r
            assign w_right = w_cell[gi+1];
        end else begin : g_rn
            assign w_right = w_cell[gi];
        end
        swm_cell #(
            .SW    (SW),
            .CNT_W (CNT_W),
            .INDEX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_value (w_cell_value),
            .i_count (w_cell_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell[gi])
        );
    end

    // median pick and doubling
    assign w_lo_idx = (w_k - CNT_W'(1)) >> 1;
    assign w_hi_idx = w_k >> 1;
    assign w_lo     = w_cell[w_lo_idx[AW-1:0]];
    assign w_hi     = w_cell[w_hi_idx[AW-1:0]];
    assign w_sum    = {{(OW-SW){w_lo[SW-1]}}, w_lo} + {{(OW-SW){w_hi[SW-1]}}, w_hi};

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= w_sum;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.median_doubled = r_out_data;

endmodule

@@ test/tb_sliding_window_median_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_window_median_unit
// Self-checking bench for the sliding window median filter. A directed table
// covers extreme samples, restarts, ties and window sizes zero (as one), two
// and above the maximum; random phases then rewrite the window size and
// stream samples under random stalls on both channels. Every result is
// compared with a table value or a model of arrival ring and sorted window.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int WIN_MAX    = 64;
    localparam int STALL_MAX  = 4000;
    localparam int N_DIR      = 24;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {EXP_NONE, EXP_VALUE, EXP_MODEL} t_exp_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [swm_pkg::SAMPLE_IN_W-1:0] value;
        logic                            restart;
        t_exp_kind                       ek;
        logic [swm_pkg::RESULT_W-1:0]    want;
    } t_dir_row;

    localparam logic [swm_pkg::SAMPLE_IN_W-1:0] S_MAX = 32'h7fff_ffff;
    localparam logic [swm_pkg::SAMPLE_IN_W-1:0] S_MIN = 32'h8000_0000;

    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{ROW_ITEM, S_MAX,         1'b0, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, S_MIN,         1'b0, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, 32'h0,         1'b0, EXP_VALUE, 33'h0_0000_0000},
        '{ROW_ITEM, S_MAX,         1'b0, EXP_VALUE, 33'h0_0000_0000},
        '{ROW_ITEM, S_MAX,         1'b0, EXP_VALUE, 33'h0_ffff_fffe},
        '{ROW_ITEM, S_MIN,         1'b1, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, S_MIN,         1'b0, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, S_MIN,         1'b0, EXP_VALUE, 33'h1_0000_0000},
        '{ROW_ITEM, 32'd5,         1'b0, EXP_MODEL, 33'h0_0000_0000},
        '{ROW_ITEM, 32'd5,         1'b0, EXP_MODEL, 33'h0_0000_0000},
        '{ROW_ITEM, 32'd5,         1'b0, EXP_VALUE, 33'h0_0000_000a},
        '{ROW_CFG,  32'd0,         1'b0, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, 32'hffff_ffff, 1'b0, EXP_VALUE, 33'h1_ffff_fffe},
        '{ROW_ITEM, S_MAX,         1'b1, EXP_VALUE, 33'h0_ffff_fffe},
        '{ROW_ITEM, 32'h0,         1'b0, EXP_MODEL, 33'h0_0000_0000},
        '{ROW_CFG,  32'd2,         1'b0, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, 32'd3,         1'b0, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, 32'd4,         1'b0, EXP_VALUE, 33'h0_0000_0007},
        '{ROW_ITEM, 32'hffff_fffc, 1'b0, EXP_MODEL, 33'h0_0000_0000},
        '{ROW_ITEM, S_MIN,         1'b0, EXP_MODEL, 33'h0_0000_0000},
        '{ROW_ITEM, 32'd9,         1'b1, EXP_NONE,  33'h0_0000_0000},
        '{ROW_CFG,  32'd127,       1'b0, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, 32'd1,         1'b0, EXP_NONE,  33'h0_0000_0000},
        '{ROW_ITEM, 32'd2,         1'b0, EXP_NONE,  33'h0_0000_0000}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [swm_pkg::CFG_W-1:0] cfg_wdata;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();

    sliding_window_median_unit #(
        .WINDOW_MAX   (WIN_MAX),
        .SAMPLE_WIDTH (swm_pkg::SAMPLE_IN_W)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // window model
    logic [swm_pkg::CFG_W-1:0]              win_cfg = swm_pkg::WINDOW_SIZE_RESET;
    logic signed [swm_pkg::SAMPLE_IN_W-1:0] arrival_ring [WIN_MAX];
    logic signed [swm_pkg::SAMPLE_IN_W-1:0] sorted_win   [WIN_MAX];
    int unsigned                            fill_cnt;
    int unsigned                            oldest_idx;

    logic signed [swm_pkg::RESULT_W-1:0]    median_exp_q [$];
    logic signed [swm_pkg::RESULT_W-1:0]    median_want;
    int unsigned                            fail_cnt = 0;
    int unsigned                            stall_cnt = 0;
    bit                                     no_idle;

    function automatic void sorted_put(input int unsigned n,
                                       input logic signed [swm_pkg::SAMPLE_IN_W-1:0] smp);
        int unsigned i;
        i = n;
        while (i > 0 && sorted_win[i-1] > smp) begin
            sorted_win[i] = sorted_win[i-1];
            i--;
        end
        sorted_win[i] = smp;
    endfunction

    function automatic bit median_step(input logic signed [swm_pkg::SAMPLE_IN_W-1:0] smp,
                                       input logic rs,
                                       output logic signed [swm_pkg::RESULT_W-1:0] med);
        int unsigned k;
        int unsigned p;
        int unsigned i;
        int unsigned lo;
        int unsigned hi;
        med = '0;
        k = (win_cfg < 1) ? 1 : (win_cfg > WIN_MAX) ? WIN_MAX : win_cfg;
        if (rs) begin
            fill_cnt   = 0;
            oldest_idx = 0;
        end
        if (fill_cnt < k) begin
            arrival_ring[fill_cnt] = smp;
            sorted_put(fill_cnt, smp);
            fill_cnt++;
            oldest_idx = 0;
            if (fill_cnt < k) return 1'b0;
        end else begin
            p = oldest_idx % k;
            i = 0;
            while (i < k && sorted_win[i] != arrival_ring[p]) i++;
            if (i < k) begin
                for (; i + 1 < k; i++) sorted_win[i] = sorted_win[i+1];
            end
            sorted_put(k - 1, smp);
            arrival_ring[p] = smp;
            oldest_idx = (p + 1) % k;
        end
        hi  = k / 2;
        lo  = (k % 2 == 1) ? hi : hi - 1;
        med = {sorted_win[lo][swm_pkg::SAMPLE_IN_W-1], sorted_win[lo]}
            + {sorted_win[hi][swm_pkg::SAMPLE_IN_W-1], sorted_win[hi]};
        return 1'b1;
    endfunction

    function automatic void note_fail(input string what,
                                      input logic [swm_pkg::RESULT_W-1:0] want,
                                      input logic [swm_pkg::RESULT_W-1:0] got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    task automatic settle(input int n);
        while (median_exp_q.size() != 0) @(posedge clk);
        repeat (n) @(posedge clk);
    endtask

    task automatic set_window(input logic [swm_pkg::CFG_W-1:0] wsz);
        in_ch.valid <= 1'b0;
        settle(8);
        cfg_we    <= 1'b1;
        cfg_wdata <= wsz;
        @(posedge clk);
        cfg_we     <= 1'b0;
        win_cfg    = wsz;
        fill_cnt   = 0;
        oldest_idx = 0;
    endtask

    task automatic push_sample(input logic signed [swm_pkg::SAMPLE_IN_W-1:0] smp,
                               input logic rs,
                               input t_exp_kind ek,
                               input logic signed [swm_pkg::RESULT_W-1:0] want);
        logic signed [swm_pkg::RESULT_W-1:0] med;
        bit                                  has;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 35) begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= smp;
        in_ch.restart <= rs;
        do @(posedge clk); while (!in_ch.ready);
        has = median_step(smp, rs, med);
        case (ek)
            EXP_VALUE: median_exp_q = {median_exp_q, want};
            EXP_MODEL: if (has) median_exp_q = {median_exp_q, med};
            default: ;
        endcase
    endtask

    // result side: random stalls and checking
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (median_exp_q.size() == 0) begin
                note_fail("unexpected result", 'x, out_ch.median_doubled);
            end else begin
                median_want = median_exp_q.pop_front();
                if (median_want !== out_ch.median_doubled)
                    note_fail("median_doubled", median_want, out_ch.median_doubled);
            end
        end
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("tb_sliding_window_median_unit: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned                            ph;
        int unsigned                            n_items;
        int unsigned                            n_rand;
        int unsigned                            k;
        logic [swm_pkg::CFG_W-1:0]              wsz;
        logic signed [swm_pkg::SAMPLE_IN_W-1:0] smp;
        logic [swm_pkg::CFG_W-1:0]              ph_sizes [6];

        ph_sizes = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd0, 7'd4};
        fill_cnt   = 0;
        oldest_idx = 0;
        no_idle    = 1'b0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.sample   <= '0;
        in_ch.restart  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_TAB[r].kind == ROW_CFG)
                set_window(DIR_TAB[r].value[swm_pkg::CFG_W-1:0]);
            else
                push_sample(DIR_TAB[r].value, DIR_TAB[r].restart, DIR_TAB[r].ek,
                            DIR_TAB[r].want);
        end

        n_rand = 0;
        ph     = 0;
        while (n_rand < 600) begin
            if (ph < 6)
                wsz = ph_sizes[ph];
            else if ($urandom_range(0, 3) == 0)
                wsz = swm_pkg::CFG_W'($urandom_range(0, 127));
            else
                wsz = swm_pkg::CFG_W'($urandom_range(1, 12));
            set_window(wsz);
            no_idle = (ph == 3);
            k = (wsz < 1) ? 1 : (wsz > WIN_MAX) ? WIN_MAX : wsz;
            n_items = k + $urandom_range(20, 60);
            for (int i = 0; i < n_items; i++) begin
                case ($urandom_range(0, 9))
                    0:       smp = S_MIN;
                    1:       smp = S_MAX;
                    2, 3, 4: smp = $signed($urandom_range(0, 8)) - 4;
                    default: smp = $urandom;
                endcase
                push_sample(smp, $urandom_range(0, 39) == 0, EXP_MODEL, '0);
                n_rand++;
            end
            no_idle = 1'b0;
            ph++;
        end

        in_ch.valid <= 1'b0;
        settle(10);
        if (fail_cnt == 0)
            $display("tb_sliding_window_median_unit: PASS");
        else
            $display("tb_sliding_window_median_unit: FAIL");
        $finish;
    end

endmodule
